// ===== src/p1305_pkg.sv =====
// ----------------------------------------------------------------------------
// p1305_pkg: shared types, constants and helpers
// Sequencer encodings, multiplier request/response, key clamp and padding.
// ----------------------------------------------------------------------------
package p1305_pkg;

    localparam int LIMB_W = 26;
    localparam int NLIMB  = 5;
    localparam int ACC_W  = 64;
    localparam int A_W    = 28;
    localparam int PROD_W = 57;

    localparam logic [25:0] LIMB_MASK = 26'h3ffffff;
    localparam logic [25:0] R_MASK [NLIMB] = '{
        26'h3ffffff, 26'h3ffff03, 26'h3ffc0ff, 26'h3f03fff, 26'h00fffff
    };

    localparam logic [1:0] CFG_R_LO = 2'd0;
    localparam logic [1:0] CFG_R_HI = 2'd1;
    localparam logic [1:0] CFG_S_LO = 2'd2;
    localparam logic [1:0] CFG_S_HI = 2'd3;

    localparam logic [5:0] FULL_COUNT = 6'd32;
    localparam logic [5:0] HALF_COUNT = 6'd16;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEL,
        S_MUL,
        S_NORM,
        S_TAG
    } t_state;

    typedef enum logic [2:0] {
        PH_SQ,
        PH_A0,
        PH_A1,
        PH_SUM,
        PH_FIN
    } t_phase;

    typedef struct packed {
        logic            valid;
        logic [2:0]      idx;
        logic            fold;
        logic [A_W-1:0]  a;
        logic [25:0]     b;
    } t_mreq;

    typedef struct packed {
        logic              valid;
        logic [2:0]        idx;
        logic [PROD_W-1:0] p;
    } t_prod;

    function automatic t_phase next_phase(t_phase ph);
        t_phase res;
        case (ph)
            PH_SQ:   res = PH_A0;
            PH_A0:   res = PH_A1;
            PH_A1:   res = PH_SUM;
            PH_SUM:  res = PH_FIN;
            default: res = PH_FIN;
        endcase
        return res;
    endfunction

    // keep n bytes, place 0x01 right after them, zero the rest
    function automatic logic [127:0] pad16(logic [127:0] v, logic [3:0] n);
        logic [127:0] res;
        for (int k = 0; k < 16; k++) begin
            if (5'(k) < {1'b0, n}) begin
                res[8*k +: 8] = v[8*k +: 8];
            end else if (5'(k) == {1'b0, n}) begin
                res[8*k +: 8] = 8'h01;
            end else begin
                res[8*k +: 8] = 8'h00;
            end
        end
        return res;
    endfunction

endpackage

// ===== src/p1305_mul.sv =====
// ----------------------------------------------------------------------------
// p1305_mul: shared limb multiplier
// One 28 x 29 bit product per cycle; folded terms take b*5. Output registered.
// ----------------------------------------------------------------------------
module p1305_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  p1305_pkg::t_mreq   i_req,
    output p1305_pkg::t_prod   o_prod
);

    logic [28:0]                   w_b;
    logic [p1305_pkg::PROD_W-1:0]  w_p;
    p1305_pkg::t_prod              r_prod;

    // wrap-around term of 2^130 = 5 mod p
    assign w_b = i_req.fold ? ({1'b0, i_req.b, 2'b00} + {3'b000, i_req.b})
                            : {3'b000, i_req.b};
    assign w_p = p1305_pkg::PROD_W'(i_req.a) * p1305_pkg::PROD_W'(w_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod.valid <= 1'b0;
        end else begin
            r_prod.valid <= i_req.valid;
        end
        r_prod.idx <= i_req.idx;
        r_prod.p   <= w_p;
    end

    assign o_prod = r_prod;

endmodule

// ===== src/poly1305_two_block_mac.sv =====
// ----------------------------------------------------------------------------
// poly1305_two_block_mac: Poly1305 MAC, two 16-byte blocks per item
// Iterative engine built around one shared limb multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Write the key over the cfg channel (index 0/1: r low/high, 2/3: s
//   low/high) while idle; o_cfg_ready is always high. Feed items of 32
//   message bytes on s_axis; byte count rides in tdata, tlast ends the
//   message. Only the last item yields a 16-byte tag on m_axis.
// Operation:
//   Each modular multiply issues 25 partial products on the shared
//   multiplier, drains the last product and runs 15 carry steps. A full
//   item costs two multiplies plus a 15-step sum fold. The first item
//   after an r write adds one multiply for r^2. A last item adds a final
//   reduction and the tag. s_axis_tready is low while busy.
// Reset: clears the keys, accumulator, r^2 and state; idle afterwards.
// Stall: the tag waits in an output register; the next item is taken
//   meanwhile, and only a following tag waits for m_axis_tready.
// ----------------------------------------------------------------------------
module poly1305_two_block_mac (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [263:0] s_axis_tdata,  // bytes_a, bytes_b, bytes_c, bytes_d, byte_count
    input  logic         s_axis_tlast,  // last_item
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,  // tag_low, tag_high
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data
);

    p1305_pkg::t_state r_state, n_state;
    p1305_pkg::t_phase r_phase;

    logic [63:0]  r_key_r_lo, r_key_r_hi, r_key_s_lo, r_key_s_hi;
    logic         r_sq_ready;
    logic [25:0]  r_r2 [5];
    logic [26:0]  r_h  [5];
    logic [26:0]  r_t  [5];
    logic [63:0]  r_x  [5];
    logic [27:0]  r_a  [5];
    logic [25:0]  r_b  [5];
    logic [2:0]   r_mi, r_mj;
    logic         r_mdone;
    logic [1:0]   r_np;
    logic [2:0]   r_ni;
    logic [255:0] r_msg;
    logic [5:0]   r_n;
    logic         r_last;
    logic [127:0] r_tag;
    logic         r_out_valid;

    logic         w_in_acc, w_cfg_acc, w_out_free;
    logic         w_pair, w_need0, w_need1, w_do, w_norm_done;
    logic [129:0] w_blk0, w_blk1, w_rv;
    logic [25:0]  w_rc [5];
    logic [27:0]  w_a0 [5];
    logic [27:0]  w_a1 [5];
    logic [63:0]  w_g  [5];
    logic [63:0]  w_hv [5];
    logic [63:0]  w_lo, w_hi;
    logic [127:0] w_tag;
    logic [2:0]   w_bidx;
    logic [5:0]   w_cnt;
    p1305_pkg::t_mreq w_req;
    p1305_pkg::t_prod w_prod;

    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_cfg_acc  = i_cfg_valid && o_cfg_ready;
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_cnt      = (s_axis_tdata[261:256] > p1305_pkg::FULL_COUNT)
                        ? p1305_pkg::FULL_COUNT : s_axis_tdata[261:256];

    // block plan of the held item
    assign w_pair  = !r_last || (r_n == p1305_pkg::FULL_COUNT);
    assign w_need0 = w_pair || (r_n != 6'd0);
    assign w_need1 = w_pair || (r_n > p1305_pkg::HALF_COUNT);
    assign w_blk0  = (w_pair || (r_n >= p1305_pkg::HALF_COUNT))
                     ? {2'b01, r_msg[127:0]}
                     : {2'b00, p1305_pkg::pad16(r_msg[127:0], r_n[3:0])};
    assign w_blk1  = w_pair ? {2'b01, r_msg[255:128]}
                            : {2'b00, p1305_pkg::pad16(r_msg[255:128], r_n[3:0])};
    assign w_rv    = {2'b00, r_key_r_hi, r_key_r_lo};

    always_comb begin
        for (int k = 0; k < 5; k++) begin
            w_rc[k] = w_rv[26*k +: 26] & p1305_pkg::R_MASK[k];
            w_a0[k] = {1'b0, r_h[k]} + {2'b00, w_blk0[26*k +: 26]};
            w_a1[k] = (w_pair ? 28'd0 : {1'b0, r_h[k]}) + {2'b00, w_blk1[26*k +: 26]};
        end
    end

    // whether the current phase has work in the select state
    always_comb begin
        case (r_phase)
            p1305_pkg::PH_SQ:  w_do = !r_sq_ready;
            p1305_pkg::PH_A0:  w_do = w_need0;
            p1305_pkg::PH_A1:  w_do = w_need1;
            p1305_pkg::PH_SUM: w_do = w_pair;
            default:           w_do = r_last;
        endcase
    end

    assign w_norm_done = (r_np == 2'd2) && (r_ni == 3'd4);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            p1305_pkg::S_IDLE: begin
                if (w_in_acc) n_state = p1305_pkg::S_SEL;
            end
            p1305_pkg::S_SEL: begin
                if (w_do) begin
                    if (r_phase == p1305_pkg::PH_SUM || r_phase == p1305_pkg::PH_FIN)
                        n_state = p1305_pkg::S_NORM;
                    else
                        n_state = p1305_pkg::S_MUL;
                end else if (r_phase == p1305_pkg::PH_FIN) begin
                    n_state = p1305_pkg::S_IDLE;
                end
            end
            p1305_pkg::S_MUL: begin
                if (r_mdone) n_state = p1305_pkg::S_NORM;
            end
            p1305_pkg::S_NORM: begin
                if (w_norm_done)
                    n_state = (r_phase == p1305_pkg::PH_FIN) ? p1305_pkg::S_TAG
                                                             : p1305_pkg::S_SEL;
            end
            p1305_pkg::S_TAG: begin
                if (w_out_free) n_state = p1305_pkg::S_IDLE;
            end
            default: n_state = p1305_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_axis_tready = (r_state == p1305_pkg::S_IDLE);
        o_cfg_ready   = 1'b1;
        m_axis_tvalid = r_out_valid;
        m_axis_tdata  = r_tag;
    end

    // multiplier request: d[j] += a[i] * b[j-i], wrapped terms times 5
    assign w_bidx = (r_mj >= r_mi) ? (r_mj - r_mi) : (r_mj + 3'd5 - r_mi);
    always_comb begin
        w_req.valid = (r_state == p1305_pkg::S_MUL) && !r_mdone;
        w_req.idx   = r_mj;
        w_req.fold  = (r_mi > r_mj);
        w_req.a     = r_a[r_mi];
        w_req.b     = r_b[w_bidx];
    end

    p1305_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_prod  (w_prod)
    );

    // final reduction and pad add
    always_comb begin
        w_g[0] = r_x[0] + 64'd5;
        for (int k = 0; k < 4; k++) begin
            w_g[k+1] = r_x[k+1] + (w_g[k] >> 26);
        end
        for (int k = 0; k < 5; k++) begin
            w_hv[k] = ((w_g[4] >> 26) != 64'd0) ? (w_g[k] & 64'h3ffffff) : r_x[k];
        end
        w_lo  = w_hv[0] | (w_hv[1] << 26) | (w_hv[2] << 52);
        w_hi  = (w_hv[2] >> 12) | (w_hv[3] << 14) | (w_hv[4] << 40);
        w_tag = {w_hi, w_lo} + {r_key_s_hi, r_key_s_lo};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= p1305_pkg::S_IDLE;
            r_phase     <= p1305_pkg::PH_SQ;
            r_key_r_lo  <= '0;
            r_key_r_hi  <= '0;
            r_key_s_lo  <= '0;
            r_key_s_hi  <= '0;
            r_sq_ready  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mdone     <= 1'b0;
            r_mi        <= '0;
            r_mj        <= '0;
            r_np        <= '0;
            r_ni        <= '0;
            for (int k = 0; k < 5; k++) begin
                r_h[k]  <= '0;
                r_r2[k] <= '0;
            end
        end else begin
            r_state <= n_state;

            if (r_state == p1305_pkg::S_TAG && w_out_free) begin
                r_tag       <= w_tag;
                r_out_valid <= 1'b1;
                for (int k = 0; k < 5; k++) r_h[k] <= '0;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (w_in_acc) begin
                r_msg   <= s_axis_tdata[255:0];
                r_n     <= w_cnt;
                r_last  <= s_axis_tlast;
                r_phase <= p1305_pkg::PH_SQ;
            end

            if (r_state == p1305_pkg::S_SEL) begin
                if (!w_do) begin
                    r_phase <= p1305_pkg::next_phase(r_phase);
                end else begin
                    r_mi    <= '0;
                    r_mj    <= '0;
                    r_mdone <= 1'b0;
                    for (int k = 0; k < 5; k++) begin
                        case (r_phase)
                            p1305_pkg::PH_SQ: begin
                                r_a[k] <= {2'b00, w_rc[k]};
                                r_b[k] <= w_rc[k];
                                r_x[k] <= '0;
                            end
                            p1305_pkg::PH_A0: begin
                                r_a[k] <= w_a0[k];
                                r_b[k] <= w_pair ? r_r2[k] : w_rc[k];
                                r_x[k] <= '0;
                            end
                            p1305_pkg::PH_A1: begin
                                r_a[k] <= w_a1[k];
                                r_b[k] <= w_rc[k];
                                r_x[k] <= '0;
                            end
                            p1305_pkg::PH_SUM: r_x[k] <= 64'(r_h[k]) + 64'(r_t[k]);
                            default:           r_x[k] <= 64'(r_h[k]);
                        endcase
                    end
                end
            end

            if (r_state == p1305_pkg::S_MUL && !r_mdone) begin
                if (r_mi == 3'd4) begin
                    r_mi <= '0;
                    if (r_mj == 3'd4) r_mdone <= 1'b1;
                    else              r_mj <= r_mj + 3'd1;
                end else begin
                    r_mi <= r_mi + 3'd1;
                end
            end

            if (w_prod.valid)
                r_x[w_prod.idx] <= r_x[w_prod.idx] + 64'(w_prod.p);

            // carry propagation, one limb per cycle, three passes
            if (r_state == p1305_pkg::S_NORM) begin
                if (r_ni == 3'd4) begin
                    r_x[4] <= r_x[4] & 64'h3ffffff;
                    r_x[0] <= r_x[0] + ((r_x[4] >> 26) << 2) + (r_x[4] >> 26);
                end else begin
                    r_x[r_ni]        <= r_x[r_ni] & 64'h3ffffff;
                    r_x[r_ni + 3'd1] <= r_x[r_ni + 3'd1] + (r_x[r_ni] >> 26);
                end
                if (w_norm_done) begin
                    r_np <= '0;
                    r_ni <= '0;
                    if (r_phase != p1305_pkg::PH_FIN)
                        r_phase <= p1305_pkg::next_phase(r_phase);
                    for (int k = 0; k < 5; k++) begin
                        case (r_phase)
                            p1305_pkg::PH_SQ: r_r2[k] <= k == 4 ? r_x[k][25:0]
                                                                : r_x[k][25:0];
                            p1305_pkg::PH_A0: r_h[k] <= r_x[k][26:0];
                            p1305_pkg::PH_A1: begin
                                if (w_pair) r_t[k] <= r_x[k][26:0];
                                else        r_h[k] <= r_x[k][26:0];
                            end
                            p1305_pkg::PH_SUM: r_h[k] <= r_x[k][26:0];
                            default: ;
                        endcase
                    end
                    if (r_phase == p1305_pkg::PH_SQ) r_sq_ready <= 1'b1;
                end else if (r_ni == 3'd4) begin
                    r_ni <= '0;
                    r_np <= r_np + 2'd1;
                end else begin
                    r_ni <= r_ni + 3'd1;
                end
            end

            if (w_cfg_acc) begin
                case (i_cfg_index)
                    p1305_pkg::CFG_R_LO: begin
                        r_key_r_lo <= i_cfg_data;
                        r_sq_ready <= 1'b0;
                    end
                    p1305_pkg::CFG_R_HI: begin
                        r_key_r_hi <= i_cfg_data;
                        r_sq_ready <= 1'b0;
                    end
                    p1305_pkg::CFG_S_LO: r_key_s_lo <= i_cfg_data;
                    p1305_pkg::CFG_S_HI: r_key_s_hi <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

`ifndef SYNTH
    a_prod_from_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_prod.valid |-> ($past(r_state) == p1305_pkg::S_MUL))
        else $error("multiplier product outside multiply phase");

    a_tag_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == p1305_pkg::S_TAG && w_out_free) |=> r_out_valid)
        else $error("tag not presented");

    a_square_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == p1305_pkg::S_NORM && w_norm_done && r_phase == p1305_pkg::PH_SQ
         && !w_cfg_acc) |=> r_sq_ready)
        else $error("r squared not marked ready");

    a_mul_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == p1305_pkg::S_MUL && r_mdone) |=> (r_state == p1305_pkg::S_NORM))
        else $error("multiply phase did not hand over to carry phase");
`endif

endmodule
